// ----- rtl/core/date_sorted_event_queue_defines.svh -----
// Assertion macros for the date sorted event queue.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef DATE_SORTED_EVENT_QUEUE_DEFINES_SVH
`define DATE_SORTED_EVENT_QUEUE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DSQ_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DSQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/dsq_pkg.sv -----
// Package for the date sorted event queue: beat types, codes, cell control.
// No dependencies.
package dsq_pkg;

  localparam int unsigned OCC_W = 7;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LIST   = 2'd2,
    OP_NONE   = 2'd3
  } dsq_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } dsq_status_e;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_REMOVE,
    CMD_ROTATE
  } dsq_cmd_e;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] date;
    logic [7:0]  level;
  } dsq_entry_t;

  // Broadcast to every cell each cycle.
  typedef struct packed {
    dsq_cmd_e    cmd;
    dsq_entry_t  new_entry;
    logic [15:0] rid;
  } dsq_ctrl_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] event_date;
    logic [7:0]  event_level;
    logic [15:0] remove_id;
  } dsq_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [15:0]      out_id;
    logic [31:0]      out_date;
    logic [7:0]       out_level;
    logic [OCC_W-1:0] occupancy;
    logic             last;
  } dsq_out_t;

endpackage

// ----- rtl/core/dsq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
// Depends on dsq_pkg.
module dsq_cell (
  input  logic               clk_i,
  input  dsq_pkg::dsq_ctrl_t ctrl_i,
  input  logic               occupied_i,  // slot index below the count
  input  logic               tail_i,      // last occupied slot
  input  dsq_pkg::dsq_entry_t left_i,
  input  dsq_pkg::dsq_entry_t right_i,
  input  dsq_pkg::dsq_entry_t head_i,
  input  logic               gt_left_i,   // new entry goes after the left slot
  input  logic               found_left_i,
  output dsq_pkg::dsq_entry_t entry_o,
  output logic               gt_o,
  output logic               found_o,
  output logic               hit_o
);
  import dsq_pkg::*;

  dsq_entry_t entry_q, entry_d;
  logic       match;

  assign gt_o    = occupied_i && (ctrl_i.new_entry.date > entry_q.date);
  assign match   = occupied_i && (entry_q.id == ctrl_i.rid);
  assign found_o = found_left_i | match;
  assign hit_o   = match & ~found_left_i;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.cmd)
      CMD_INSERT: begin
        priority if (gt_o) entry_d = entry_q;
        else if (gt_left_i) entry_d = ctrl_i.new_entry;
        else entry_d = left_i;
      end
      CMD_REMOVE: begin
        if (found_o) entry_d = right_i;
      end
      CMD_ROTATE: begin
        priority if (!occupied_i) entry_d = entry_q;
        else if (tail_i) entry_d = head_i;
        else entry_d = right_i;
      end
      CMD_HOLD: entry_d = entry_q;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

// ----- rtl/core/date_sorted_event_queue.sv -----
// Top level of the date sorted event queue: control, counters, result beat.
// Depends on dsq_pkg, dsq_cell and date_sorted_event_queue_defines.svh.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+---------------------------
//  command  | start_i, busy_o         | in_i   (dsq_in_t)
//  result   | result_valid_o (strobe) | res_o  (dsq_out_t)
//
// For insert, remove and unused codes the result beat shows the cycle after
// the command is taken and busy_o stays low, so commands may come every
// cycle. A list of n entries holds busy_o high while the cell chain rotates
// through its occupied slots, cell 0 feeding the result register, so its n
// beats follow one per cycle once the list state and the result register
// are loaded; the next command is taken once busy_o falls, in the cycle the
// last beat shows. An empty list gives one beat the next cycle and leaves busy_o low.
// Reset clears the count, the id counter, the list state and the strobe;
// slot contents are not reset. The receiver cannot stall; every beat is
// valid for one cycle.
`include "date_sorted_event_queue_defines.svh"

module date_sorted_event_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  dsq_pkg::dsq_in_t  in_i,
  output logic              busy_o,
  output logic              result_valid_o,
  output dsq_pkg::dsq_out_t res_o
);
  import dsq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapC = CntW'(CAPACITY);
  localparam logic [CntW-1:0] OneC = CntW'(1);

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] left_q, left_d;    // list beats still to send
  logic            list_q, list_d;
  logic [15:0]     next_id_q, next_id_d;
  logic            valid_q, valid_d;
  dsq_out_t        result_q, result_d;

  dsq_ctrl_t       ctrl;
  dsq_entry_t      entry_w [CAPACITY];
  logic [CAPACITY-1:0] gt_w, found_w, hit_w;
  dsq_entry_t      removed;
  logic            accept, is_full, found_any;
  dsq_op_e         op;

  assign accept    = start_i & ~busy_o;
  assign op        = dsq_op_e'(in_i.op);
  assign is_full   = (count_q >= CapC);
  assign found_any = found_w[CAPACITY-1];

  // Cell control
  always_comb begin
    ctrl.new_entry.id    = next_id_q;
    ctrl.new_entry.date  = in_i.event_date;
    ctrl.new_entry.level = in_i.event_level;
    ctrl.rid             = in_i.remove_id;
    priority if (list_q) ctrl.cmd = CMD_ROTATE;
    else if (accept && op == OP_INSERT && !is_full) ctrl.cmd = CMD_INSERT;
    else if (accept && op == OP_REMOVE && found_any) ctrl.cmd = CMD_REMOVE;
    else ctrl.cmd = CMD_HOLD;
  end

  // Chain of cells
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    dsq_entry_t left_e, right_e;
    logic       gt_left, found_left;
    if (k == 0) begin : g_first
      assign left_e     = ctrl.new_entry;
      assign gt_left    = 1'b1;
      assign found_left = 1'b0;
    end else begin : g_mid
      assign left_e     = entry_w[k-1];
      assign gt_left    = gt_w[k-1];
      assign found_left = found_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_e = entry_w[k];
    end else begin : g_inner
      assign right_e = entry_w[k+1];
    end

    dsq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (CntW'(k) < count_q),
      .tail_i      (CntW'(k + 1) == count_q),
      .left_i      (left_e),
      .right_i     (right_e),
      .head_i      (entry_w[0]),
      .gt_left_i   (gt_left),
      .found_left_i(found_left),
      .entry_o     (entry_w[k]),
      .gt_o        (gt_w[k]),
      .found_o     (found_w[k]),
      .hit_o       (hit_w[k])
    );
  end

  // Deleted entry: one-hot select of the first matching cell
  always_comb begin
    removed = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      if (hit_w[k]) removed = removed | entry_w[k];
    end
  end

  // Next state and result beat
  always_comb begin
    count_d   = count_q;
    left_d    = left_q;
    list_d    = list_q;
    next_id_d = next_id_q;
    valid_d   = 1'b0;
    result_d  = result_q;

    if (list_q) begin
      valid_d            = 1'b1;
      result_d.status    = ST_OK;
      result_d.out_id    = entry_w[0].id;
      result_d.out_date  = entry_w[0].date;
      result_d.out_level = entry_w[0].level;
      result_d.occupancy = OCC_W'(count_q);
      result_d.last      = (left_q == OneC);
      left_d             = left_q - OneC;
      list_d             = (left_q != OneC);
    end else if (accept) begin
      valid_d            = 1'b1;
      result_d           = '0;
      result_d.last      = 1'b1;
      result_d.status    = ST_OK;
      result_d.occupancy = OCC_W'(count_q);
      unique case (op)
        OP_INSERT: begin
          if (is_full) begin
            result_d.status = ST_FULL;
          end else begin
            result_d.out_id    = next_id_q;
            count_d            = count_q + OneC;
            result_d.occupancy = OCC_W'(count_d);
            next_id_d          = next_id_q + 16'd1;
          end
        end
        OP_REMOVE: begin
          result_d.out_id = in_i.remove_id;
          priority if (count_q == '0) begin
            result_d.status = ST_EMPTY;
          end else if (!found_any) begin
            result_d.status = ST_NOT_FOUND;
          end else begin
            result_d.out_date  = removed.date;
            result_d.out_level = removed.level;
            count_d            = count_q - OneC;
            result_d.occupancy = OCC_W'(count_d);
          end
        end
        OP_LIST: begin
          if (count_q == '0) begin
            result_d.status = ST_EMPTY;
          end else begin
            valid_d = 1'b0;
            list_d  = 1'b1;
            left_d  = count_q;
          end
        end
        OP_NONE: begin
          result_d.status = ST_OK;
        end
        default: result_d.status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      left_q    <= '0;
      list_q    <= 1'b0;
      next_id_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      count_q   <= count_d;
      left_q    <= left_d;
      list_q    <= list_d;
      next_id_q <= next_id_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  assign busy_o         = list_q;
  assign result_valid_o = valid_q;
  assign res_o          = result_q;

  // Checks
  `DSQ_ASSERT_IMPL(a_count_cap, 1'b1, count_q <= CapC, "entry count above capacity")
  `DSQ_ASSERT_IMPL(a_list_left, list_q, left_q != '0, "list running with no beats left")
  `DSQ_ASSERT_IMPL(a_list_end, $fell(list_q), valid_q && result_q.last, "list ended without last beat")
  `DSQ_ASSERT_NEXT(a_ins_count, ctrl.cmd == CMD_INSERT, count_q == $past(count_q) + OneC, "insert did not grow count")

endmodule

// ----- verif/date_sorted_event_queue_checker.sv -----
// Checker for the date sorted event queue: keeps its own sorted copy of the
// queue, predicts every result beat and compares the strobed beats in order.
// Depends on dsq_pkg.
module date_sorted_event_queue_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_o,
  input  dsq_pkg::dsq_in_t  in_i,
  input  logic              result_valid_o,
  input  dsq_pkg::dsq_out_t res_o,
  output int                fail_count_o,
  output int                pending_o
);
  import dsq_pkg::*;

  // Shadow of the queue, index 0 holds the earliest date.
  dsq_entry_t  shadow_slots [CAPACITY];
  int unsigned shadow_count;
  logic [15:0] shadow_next_id;

  dsq_out_t    expected_beats [$];

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic push_beat(input logic [1:0] status, input logic [15:0] id,
                           input logic [31:0] date, input logic [7:0] level,
                           input logic last);
    dsq_out_t beat;
    beat.status    = status;
    beat.out_id    = id;
    beat.out_date  = date;
    beat.out_level = level;
    beat.occupancy = shadow_count[OCC_W-1:0];
    beat.last      = last;
    expected_beats.insert(expected_beats.size(), beat);
  endtask

  // Applies one accepted command to the shadow queue and queues its beats.
  task automatic apply_command(input dsq_in_t cmd);
    int unsigned pos;
    int unsigned idx;
    dsq_entry_t  gone;
    case (cmd.op)
      OP_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          push_beat(ST_FULL, '0, '0, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < shadow_count && cmd.event_date > shadow_slots[pos].date) pos++;
          for (idx = shadow_count; idx > pos; idx--) shadow_slots[idx] = shadow_slots[idx-1];
          shadow_slots[pos].id    = shadow_next_id;
          shadow_slots[pos].date  = cmd.event_date;
          shadow_slots[pos].level = cmd.event_level;
          shadow_count++;
          push_beat(ST_OK, shadow_next_id, '0, '0, 1'b1);
          shadow_next_id = shadow_next_id + 16'd1;
        end
      end
      OP_REMOVE: begin
        if (shadow_count == 0) begin
          push_beat(ST_EMPTY, cmd.remove_id, '0, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_slots[pos].id != cmd.remove_id) pos++;
          if (pos >= shadow_count) begin
            push_beat(ST_NOT_FOUND, cmd.remove_id, '0, '0, 1'b1);
          end else begin
            gone = shadow_slots[pos];
            for (idx = pos; idx + 1 < shadow_count; idx++) shadow_slots[idx] = shadow_slots[idx+1];
            shadow_count--;
            push_beat(ST_OK, cmd.remove_id, gone.date, gone.level, 1'b1);
          end
        end
      end
      OP_LIST: begin
        if (shadow_count == 0) begin
          push_beat(ST_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (idx = 0; idx < shadow_count; idx++) begin
            push_beat(ST_OK, shadow_slots[idx].id, shadow_slots[idx].date,
                      shadow_slots[idx].level, idx + 1 == shadow_count);
          end
        end
      end
      default: begin
        push_beat(ST_OK, '0, '0, '0, 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string field_name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field_name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    dsq_out_t want;
    if (!rst_ni) begin
      shadow_count   = 0;
      shadow_next_id = '0;
      expected_beats.delete();
    end else begin
      if (start_i && !busy_o) apply_command(in_i);
      if (result_valid_o) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: %0h", res_o);
          fail_count_o++;
        end else begin
          want = expected_beats.pop_front();
          check_field("status",    want.status,    res_o.status);
          check_field("out_id",    want.out_id,    res_o.out_id);
          check_field("out_date",  want.out_date,  res_o.out_date);
          check_field("out_level", want.out_level, res_o.out_level);
          check_field("occupancy", want.occupancy, res_o.occupancy);
          check_field("last",      want.last,      res_o.last);
        end
      end
    end
    pending_o = expected_beats.size();
  end

endmodule

// ----- verif/tb_date_sorted_event_queue.sv -----
// Testbench top for the date sorted event queue: clock, reset, command
// stimulus, watchdog and verdict. Depends on dsq_pkg, the block and
// date_sorted_event_queue_checker.
module tb_date_sorted_event_queue;
  import dsq_pkg::*;

  localparam int unsigned CAPACITY       = 16;
  // The directed part sends 27 commands; this brings the total to about 470.
  localparam int unsigned RANDOM_ITEMS   = 443;
  // No command taken and no beat for this many cycles means the block hung.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  // A full list is 16 beats; drain a bit past that to catch stray beats.
  localparam int unsigned DRAIN_CYCLES   = 24;

  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  dsq_in_t   in_i;
  logic      busy_o;
  logic      result_valid_o;
  dsq_out_t  res_o;

  int        fail_count;
  int        pending_beats;
  int        quiet_cycles;
  bit        idle_on;

  // Ids seen on ok beats; remove targets are mostly drawn from here so
  // that removes actually hit live entries.
  logic [15:0] recent_ids [16];
  logic [3:0]  recent_wr;

  date_sorted_event_queue #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .in_i           (in_i),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

  date_sorted_event_queue_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .res_o          (res_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending_beats)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    recent_wr = '0;
    for (int i = 0; i < 16; i++) recent_ids[i] = '0;
  end

  always @(posedge clk_i) begin
    if (result_valid_o && res_o.status == ST_OK) begin
      recent_ids[recent_wr] <= res_o.out_id;
      recent_wr             <= recent_wr + 4'd1;
    end
  end

  // Watchdog: counts cycles with neither a command nor a result beat taken.
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || result_valid_o) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("date_sorted_event_queue test failed");
        $finish;
      end
    end
  end

  function automatic dsq_in_t make_cmd(input logic [1:0] op, input logic [31:0] date,
                                       input logic [7:0] level, input logic [15:0] rid);
    dsq_in_t cmd;
    cmd.op          = op;
    cmd.event_date  = date;
    cmd.event_level = level;
    cmd.remove_id   = rid;
    return cmd;
  endfunction

  function automatic logic [7:0] rand_level();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [15:0] rand_id();
    return 16'($urandom_range(65535));
  endfunction

  // Dates cluster on a few small values so equal dates are common.
  function automatic logic [31:0] pick_date();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return $urandom_range(7);
    if (r == 4) return 32'd0;
    if (r == 5) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Drives one command beat; returns in the time step of the edge that took
  // it, with start_i still high. Idle cycles go in front, with junk on in_i.
  task automatic send_cmd(input dsq_in_t cmd);
    while (idle_on && $urandom_range(99) < 34) begin
      start_i <= 1'b0;
      in_i    <= make_cmd(2'($urandom_range(3)), $urandom, rand_level(), rand_id());
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    in_i    <= cmd;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] rid;
    logic [1:0]  op;
    int unsigned r;
    bit          insert_heavy;

    rst_ni  <= 1'b0;
    start_i <= 1'b0;
    in_i    <= '0;
    idle_on  = 1'b1;
    repeat (9) @(posedge clk_i);
    rst_ni  <= 1'b1;
    @(posedge clk_i);

    // --- directed part ---
    // Empty queue: list, remove and the unused code.
    send_cmd(make_cmd(OP_LIST,   $urandom, rand_level(), rand_id()));
    send_cmd(make_cmd(OP_REMOVE, $urandom, rand_level(), 16'hFFFF));
    send_cmd(make_cmd(OP_NONE,   32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
    // Date extremes; second zero date must land ahead of the first one.
    send_cmd(make_cmd(OP_INSERT, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
    send_cmd(make_cmd(OP_INSERT, 32'd0, 8'h00, 16'h0000));
    send_cmd(make_cmd(OP_INSERT, 32'd0, 8'h33, 16'h0000));
    send_cmd(make_cmd(OP_INSERT, 32'h8000_0000, 8'hA5, 16'h0000));
    send_cmd(make_cmd(OP_LIST,   '0, '0, '0));
    // Missing id, then a hit in the middle of the queue.
    send_cmd(make_cmd(OP_REMOVE, '0, '0, 16'hFFFF));
    send_cmd(make_cmd(OP_REMOVE, '0, '0, 16'd1));
    // Fill to capacity, then one insert too many.
    repeat (13) send_cmd(make_cmd(OP_INSERT, $urandom, rand_level(), rand_id()));
    send_cmd(make_cmd(OP_INSERT, 32'h1234_5678, 8'h77, '0));
    send_cmd(make_cmd(OP_LIST,   '0, '0, '0));
    // Tail and head removes.
    send_cmd(make_cmd(OP_REMOVE, '0, '0, 16'd0));
    send_cmd(make_cmd(OP_REMOVE, '0, '0, 16'd2));

    // --- random part ---
    // Alternating insert-heavy and remove-heavy stretches push the queue
    // to full and to empty; items 200..299 run without idling.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on      = !(i >= 200 && i < 300);
      insert_heavy = ((i / 90) % 2) == 0;
      r = $urandom_range(99);
      if (r < (insert_heavy ? 55 : 20)) begin
        op = OP_INSERT;
      end else if (r < (insert_heavy ? 75 : 70)) begin
        op = OP_REMOVE;
      end else if (r < 92) begin
        op = OP_LIST;
      end else begin
        op = OP_NONE;
      end
      if ($urandom_range(99) < 75) begin
        rid = recent_ids[4'($urandom_range(15))];
      end else begin
        rid = rand_id();
      end
      send_cmd(make_cmd(op, pick_date(), rand_level(), rid));
    end
    start_i <= 1'b0;

    // Sample the pending count away from the clock edge.
    while (pending_beats != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("date_sorted_event_queue test passed");
    end else begin
      $display("date_sorted_event_queue test failed");
    end
    $finish;
  end

endmodule
